/* hdl/ffc_pkg.sv */
package ffc_pkg;

  // Datapath widths
  localparam int MAG_W     = 60;   // magnitude of a value
  localparam int VAL_W     = 61;   // signed value
  localparam int AU_W      = 62;   // shared adder
  localparam int PROD_W    = 120;  // full product
  localparam int DVD_W     = 80;   // dividend / quotient
  localparam int CNT_W     = 7;
  localparam int MUL_STEPS = 60;
  localparam int DIV_STEPS = 80;

  // Fixed-point scale: one unit is one millionth
  localparam logic [19:0] SCALE      = 20'd1000000;
  localparam logic [19:0] HALF_SCALE = 20'd500000;

  // Key codes
  localparam logic [3:0] KEY_DIGIT       = 4'd0;
  localparam logic [3:0] KEY_POINT       = 4'd1;
  localparam logic [3:0] KEY_ADD         = 4'd2;
  localparam logic [3:0] KEY_SUB         = 4'd3;
  localparam logic [3:0] KEY_MUL         = 4'd4;
  localparam logic [3:0] KEY_DIV         = 4'd5;
  localparam logic [3:0] KEY_EQUAL       = 4'd6;
  localparam logic [3:0] KEY_SIGN        = 4'd7;
  localparam logic [3:0] KEY_RECIP       = 4'd8;
  localparam logic [3:0] KEY_CLEAR_ENTRY = 4'd9;
  localparam logic [3:0] KEY_ALL_CLEAR   = 4'd10;

  localparam logic [3:0] MAX_DIGIT = 4'd9;

  // Pending operation codes
  localparam logic [2:0] PEND_NONE = 3'd0;
  localparam logic [2:0] PEND_ADD  = 3'd1;
  localparam logic [2:0] PEND_SUB  = 3'd2;
  localparam logic [2:0] PEND_MUL  = 3'd3;
  localparam logic [2:0] PEND_DIV  = 3'd4;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_DABS,
    S_DIG1,
    S_DIG2,
    S_ABS_A,
    S_ABS_B,
    S_MUL,
    S_MCHK,
    S_DIV,
    S_RND,
    S_INC,
    S_SIGN,
    S_ADD,
    S_POST,
    S_DONE
  } st_e;

  // Kind of long job in flight
  typedef enum logic [1:0] {
    JOB_DIGIT,
    JOB_MUL,
    JOB_DIV,
    JOB_RECIP
  } job_e;

  // 10^k, for elaboration-time constants
  function automatic logic [DVD_W-1:0] pow10(input int k);
    logic [DVD_W-1:0] r;
    r = DVD_W'(1);
    for (int i = 0; i < k; i++) begin
      r = DVD_W'(r * DVD_W'(10));
    end
    return r;
  endfunction

  // Weight of fraction digit number k: 10^(5-k)
  function automatic logic [19:0] frac_weight(input logic [2:0] place);
    logic [19:0] w;
    case (place)
      3'd0:    w = 20'd100000;
      3'd1:    w = 20'd10000;
      3'd2:    w = 20'd1000;
      3'd3:    w = 20'd100;
      3'd4:    w = 20'd10;
      3'd5:    w = 20'd1;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

endpackage

/* hdl/four_function_calculator_core.sv */
// Keypad calculator core. Each accepted key transaction (op_i, digit_i) yields one
// result transaction: the shown value in signed millionths, the error flag, a
// rejected-digit flag and the pending operation. All arithmetic runs on one
// shared 62-bit adder/subtractor under a small sequencer, one key at a time; the
// core stalls its input until the current key is finished. A finished result
// sits in an output register until it is taken. Point, sign, clear, unknown
// codes, a digit above nine and the reciprocal of zero finish straight from
// decode; equal or an operator with nothing pending, and a division by zero,
// pass through the post step only; add/sub use S_ADD. A fraction digit adds its
// weighted value in S_DIG1; an integer digit is scaled by ten in S_DIG1 and the
// digit is added in S_DIG2. Reciprocal runs the 80-step restoring divide;
// multiply or divide runs the 60-step shift-add multiply followed by the 80-step
// divide, all on the same adder, and a multiply that overflows stops after the
// multiply. The next key can be taken in the cycle after the result register loads.
module four_function_calculator_core
  import ffc_pkg::*;
#(
  parameter int FRAC_DIGITS = 6,
  parameter int INT_DIGITS  = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [3:0]              op_i,
  input  logic [3:0]              digit_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] shown_value_o,
  output logic                    error_o,
  output logic                    rejected_o,
  output logic [2:0]              pending_o
);

  // Range constants
  localparam logic [MAG_W-1:0] MAXV    = MAG_W'(pow10(INT_DIGITS + 6) - DVD_W'(1));
  localparam logic [MAG_W-1:0] DIG_LIM = MAG_W'(pow10(INT_DIGITS + 5));
  localparam logic [DVD_W-1:0] MUL_LIM = pow10(INT_DIGITS + 12) - DVD_W'(HALF_SCALE);
  localparam logic [DVD_W-1:0] QLIM    = pow10(INT_DIGITS + 6);
  localparam logic [DVD_W-1:0] RECIP_NUM = pow10(12);
  localparam logic signed [AU_W-1:0] MAXV_W  = $signed({2'b00, MAXV});
  localparam logic signed [AU_W-1:0] NMAXV_W = -MAXV_W;
  localparam logic signed [VAL_W-1:0] MAXV_S  = $signed({1'b0, MAXV});

  // Architectural state
  logic [VAL_W-1:0] entry_q, entry_d;
  logic [VAL_W-1:0] first_q, first_d;
  logic [2:0]       pend_q, pend_d;
  logic             frac_mode_q, frac_mode_d;
  logic [2:0]       frac_place_q, frac_place_d;
  logic             new_entry_q, new_entry_d;
  logic             err_q, err_d;

  // Sequencer and work registers
  st_e              state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]       key_q, key_d;
  logic [3:0]       digit_q, digit_d;
  job_e             job_q, job_d;
  logic             neg_q, neg_d;
  logic             rnd_q, rnd_d;
  logic             rej_q, rej_d;
  logic [MAG_W-1:0] opa_q, opa_d;
  logic [MAG_W-1:0] opb_q, opb_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [MAG_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] res_q, res_d;

  // Output register
  logic             out_valid_q;
  logic             out_load;
  logic [VAL_W-1:0] out_val_q;
  logic             out_err_q, out_rej_q;
  logic [2:0]       out_pend_q;

  // Shared adder/subtractor
  logic [AU_W-1:0] au_a, au_b;
  logic            au_sub;
  logic [AU_W:0]   au_full;
  logic [AU_W-1:0] au_sum;
  logic            au_cy;

  // Decision terms
  logic             in_acc;
  logic             is_oper;
  logic             entry_zero;
  logic             frac_full;
  logic             dig_big;
  logic             mul_ovf;
  logic             q_ovf;
  logic             res_ovf;
  logic             add_ok;
  logic [23:0]      frac_prod;
  logic [23:0]      scale_prod;
  logic [MAG_W-1:0] entry_mag;
  logic [MAG_W-1:0] first_mag;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign is_oper    = (key_q >= KEY_ADD) && (key_q <= KEY_DIV);
  assign entry_zero = (entry_q == '0);
  assign frac_full  = (frac_place_q >= 3'(FRAC_DIGITS));
  assign dig_big    = (opa_q >= DIG_LIM);
  assign mul_ovf    = (|acc_q[PROD_W-1:DVD_W]) || (acc_q[DVD_W-1:0] >= MUL_LIM);
  assign q_ovf      = (acc_q[DVD_W-1:0] >= QLIM);
  assign res_ovf    = (res_q > {1'b0, MAXV});
  assign add_ok     = ($signed(au_sum) <= MAXV_W) && ($signed(au_sum) >= NMAXV_W);
  assign frac_prod  = {20'b0, digit_q} * {4'b0, frac_weight(frac_place_q)};
  assign scale_prod = {20'b0, digit_q} * {4'b0, SCALE};

  // Magnitudes: the adder negates, a mux picks by sign
  assign entry_mag = entry_q[VAL_W-1] ? au_sum[MAG_W-1:0] : entry_q[MAG_W-1:0];
  assign first_mag = first_q[VAL_W-1] ? au_sum[MAG_W-1:0] : first_q[MAG_W-1:0];

  assign au_full = {1'b0, au_a} + {1'b0, au_b ^ {AU_W{au_sub}}} + {{AU_W{1'b0}}, au_sub};
  assign au_sum  = au_full[AU_W-1:0];
  assign au_cy   = au_full[AU_W];

  // Adder operand select
  always_comb begin
    au_a   = '0;
    au_b   = '0;
    au_sub = 1'b0;
    unique case (state_q)
      S_DEC, S_DABS, S_ABS_B: begin
        au_b   = {entry_q[VAL_W-1], entry_q};
        au_sub = 1'b1;
      end
      S_ABS_A: begin
        au_b   = {first_q[VAL_W-1], first_q};
        au_sub = 1'b1;
      end
      S_DIG1: begin
        if (frac_mode_q) begin
          au_a = {2'b00, opa_q};
          au_b = {{(AU_W-24){1'b0}}, frac_prod};
        end else begin
          // m*10 as m*8 + m*2; the result is used only when m is below the digit limit
          au_a = {2'b00, opa_q[MAG_W-4:0], 3'b000};
          au_b = {1'b0, opa_q, 1'b0};
        end
      end
      S_DIG2: begin
        au_a = {1'b0, res_q};
        au_b = {{(AU_W-24){1'b0}}, scale_prod};
      end
      S_MUL: begin
        au_a = {2'b00, acc_q[PROD_W-1:MAG_W]};
        au_b = acc_q[0] ? {2'b00, opa_q} : '0;
      end
      S_DIV: begin
        au_a   = {1'b0, rem_q, acc_q[DVD_W-1]};
        au_b   = {2'b00, opb_q};
        au_sub = 1'b1;
      end
      S_RND: begin
        au_a   = {1'b0, rem_q, 1'b0};
        au_b   = {2'b00, opb_q};
        au_sub = 1'b1;
      end
      S_INC: begin
        au_a = {2'b00, acc_q[MAG_W-1:0]};
        au_b = {{(AU_W-1){1'b0}}, rnd_q};
      end
      S_SIGN: begin
        au_b   = {1'b0, res_q};
        au_sub = neg_q;
      end
      S_ADD: begin
        au_a   = {first_q[VAL_W-1], first_q};
        au_b   = {entry_q[VAL_W-1], entry_q};
        au_sub = (pend_q == PEND_SUB);
      end
      default: begin
        au_a   = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_DEC;
      S_DEC: begin
        case (key_q)
          KEY_DIGIT: state_d = (digit_q > MAX_DIGIT) ? S_DONE : S_DABS;
          KEY_RECIP: state_d = entry_zero ? S_DONE : S_ABS_B;
          KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_EQUAL: begin
            case (pend_q)
              PEND_ADD, PEND_SUB: state_d = S_ADD;
              PEND_MUL:           state_d = S_ABS_A;
              PEND_DIV:           state_d = entry_zero ? S_POST : S_ABS_A;
              default:            state_d = S_POST;
            endcase
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DABS: state_d = S_DIG1;
      S_DIG1: begin
        if (frac_mode_q) state_d = frac_full ? S_DONE : S_SIGN;
        else             state_d = dig_big ? S_DONE : S_DIG2;
      end
      S_DIG2:  state_d = S_SIGN;
      S_ABS_A: state_d = S_ABS_B;
      S_ABS_B: state_d = (job_q == JOB_RECIP) ? S_DIV : S_MUL;
      S_MUL:   if (cnt_q == CNT_W'(MUL_STEPS - 1)) state_d = S_MCHK;
      S_MCHK:  state_d = (job_q == JOB_MUL && mul_ovf) ? S_POST : S_DIV;
      S_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_RND;
      S_RND: begin
        if (q_ovf) state_d = (job_q == JOB_RECIP) ? S_DONE : S_POST;
        else       state_d = S_INC;
      end
      S_INC:  state_d = S_SIGN;
      S_SIGN: begin
        state_d = (job_q == JOB_DIGIT || job_q == JOB_RECIP) ? S_DONE : S_POST;
      end
      S_ADD:  state_d = S_POST;
      S_POST: state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and calculator state updates
  always_comb begin
    entry_d      = entry_q;
    first_d      = first_q;
    pend_d       = pend_q;
    frac_mode_d  = frac_mode_q;
    frac_place_d = frac_place_q;
    new_entry_d  = new_entry_q;
    err_d        = err_q;
    cnt_d        = cnt_q;
    key_d        = key_q;
    digit_d      = digit_q;
    job_d        = job_q;
    neg_d        = neg_q;
    rnd_d        = rnd_q;
    rej_d        = rej_q;
    opa_d        = opa_q;
    opb_d        = opb_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    res_d        = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_d   = op_i;
          digit_d = digit_i;
          rej_d   = 1'b0;
        end
      end
      S_DEC: begin
        case (key_q)
          KEY_DIGIT: begin
            if (digit_q > MAX_DIGIT) begin
              rej_d = 1'b1;
            end else begin
              job_d = JOB_DIGIT;
              if (new_entry_q) begin
                entry_d     = '0;
                new_entry_d = 1'b0;
                frac_mode_d = 1'b0;
              end
            end
          end
          KEY_POINT: begin
            if (!frac_mode_q) begin
              frac_mode_d  = 1'b1;
              frac_place_d = '0;
              if (new_entry_q) begin
                entry_d     = '0;
                new_entry_d = 1'b0;
              end
            end
          end
          KEY_SIGN: entry_d = au_sum[VAL_W-1:0];
          KEY_RECIP: begin
            if (entry_zero) begin
              err_d = 1'b1;
            end else begin
              job_d = JOB_RECIP;
              neg_d = entry_q[VAL_W-1];
            end
          end
          KEY_CLEAR_ENTRY: begin
            entry_d     = '0;
            err_d       = 1'b0;
            frac_mode_d = 1'b0;
            new_entry_d = 1'b1;
          end
          KEY_ALL_CLEAR: begin
            entry_d      = '0;
            first_d      = '0;
            pend_d       = PEND_NONE;
            frac_mode_d  = 1'b0;
            frac_place_d = '0;
            new_entry_d  = 1'b1;
            err_d        = 1'b0;
          end
          KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV, KEY_EQUAL: begin
            // Complete the pending operation
            err_d = 1'b0;
            neg_d = entry_q[VAL_W-1] ^ first_q[VAL_W-1];
            case (pend_q)
              PEND_ADD, PEND_SUB: ;
              PEND_MUL: job_d = JOB_MUL;
              PEND_DIV: begin
                if (entry_zero) err_d = 1'b1;
                else            job_d = JOB_DIV;
              end
              default: first_d = '0;
            endcase
          end
          default: ;
        endcase
      end
      S_DABS: begin
        opa_d = entry_mag;
        neg_d = entry_q[VAL_W-1];
      end
      S_DIG1: begin
        if (frac_mode_q ? frac_full : dig_big) rej_d = 1'b1;
        else                                   res_d = au_sum[VAL_W-1:0];
      end
      S_DIG2: res_d = au_sum[VAL_W-1:0];
      S_ABS_A: opa_d = first_mag;
      S_ABS_B: begin
        // Load multiplier or dividend
        opb_d = entry_mag;
        cnt_d = '0;
        rem_d = '0;
        case (job_q)
          JOB_MUL: acc_d = {{(PROD_W-MAG_W){1'b0}}, entry_mag};
          JOB_DIV: acc_d = {{(PROD_W-MAG_W){1'b0}}, MAG_W'(SCALE)};
          default: acc_d = {{(PROD_W-DVD_W){1'b0}}, RECIP_NUM};
        endcase
      end
      S_MUL: begin
        // Shift-add step, low bits of the multiplier leave at the right
        acc_d = {au_sum[MAG_W:0], acc_q[MAG_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
      end
      S_MCHK: begin
        if (job_q == JOB_MUL) begin
          if (mul_ovf) err_d = 1'b1;
          else         opb_d = MAG_W'(SCALE);
        end
        rem_d = '0;
        cnt_d = '0;
      end
      S_DIV: begin
        // Restoring divide step, quotient bits enter at the right
        rem_d = au_cy ? au_sum[MAG_W-1:0] : {rem_q[MAG_W-2:0], acc_q[DVD_W-1]};
        acc_d[DVD_W-1:0] = {acc_q[DVD_W-2:0], au_cy};
        cnt_d = cnt_q + CNT_W'(1);
      end
      S_RND: begin
        // Round half away from zero: twice the remainder against the divisor
        rnd_d = au_cy;
        if (q_ovf) err_d = 1'b1;
      end
      S_INC: res_d = au_sum[VAL_W-1:0];
      S_SIGN: begin
        if (res_ovf) begin
          if (job_q == JOB_DIGIT) rej_d = 1'b1;
          else                    err_d = 1'b1;
        end else begin
          entry_d = au_sum[VAL_W-1:0];
          if (job_q == JOB_DIGIT && frac_mode_q) frac_place_d = frac_place_q + 3'd1;
        end
      end
      S_ADD: begin
        if (add_ok) entry_d = au_sum[VAL_W-1:0];
        else        err_d   = 1'b1;
      end
      S_POST: begin
        frac_mode_d = 1'b0;
        new_entry_d = 1'b1;
        pend_d      = PEND_NONE;
        if (is_oper) begin
          first_d = entry_q;
          pend_d  = 3'(key_q - 4'd1);
        end
      end
      default: ;
    endcase
  end

  // Control and calculator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      entry_q      <= '0;
      first_q      <= '0;
      pend_q       <= PEND_NONE;
      frac_mode_q  <= 1'b0;
      frac_place_q <= '0;
      new_entry_q  <= 1'b1;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      entry_q      <= entry_d;
      first_q      <= first_d;
      pend_q       <= pend_d;
      frac_mode_q  <= frac_mode_d;
      frac_place_q <= frac_place_d;
      new_entry_q  <= new_entry_d;
      err_q        <= err_d;
      out_valid_q  <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // Work and output payload
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    digit_q <= digit_d;
    job_q   <= job_d;
    neg_q   <= neg_d;
    rnd_q   <= rnd_d;
    rej_q   <= rej_d;
    opa_q   <= opa_d;
    opb_q   <= opb_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    if (out_load) begin
      out_val_q  <= entry_q;
      out_err_q  <= err_q;
      out_rej_q  <= rej_q;
      out_pend_q <= pend_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign shown_value_o = $signed(out_val_q);
  assign error_o       = out_err_q;
  assign rejected_o    = out_rej_q;
  assign pending_o     = out_pend_q;

`ifndef SYNTH
  // Entry never leaves the display range
  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed(entry_q) <= MAXV_S) && ($signed(entry_q) >= -MAXV_S))
    else $error("entry value out of range");

  // Only digit keys are ever rejected
  a_rej_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && rej_q) |-> (key_q == KEY_DIGIT))
    else $error("rejected flag on a non-digit key");

  // Pending code stays a legal operation
  a_pend_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_DIV)
    else $error("illegal pending operation");

  // Completing an operation starts a fresh entry
  a_post_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POST) |=> (new_entry_q && !frac_mode_q))
    else $error("entry state not reset after operation");

  // Multiply step counter stays in bounds
  a_mul_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (cnt_q < CNT_W'(MUL_STEPS)))
    else $error("multiply counter overran");
`endif

endmodule
